// ----- rtl/i2c_master_transfer_sequencer_core_macros.svh -----
// Assertion helpers for the transfer sequencer.
// Checking is compiled in for simulation and left out for synthesis.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define I2CMTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication, disabled while in reset
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`else

`define I2CMTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/i2cmts_pkg.sv -----
package i2cmts_pkg;

	// Message store size
	localparam int BUFFER_DEPTH = 16;

	localparam int PTR_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int WIDE_W = (PTR_W > 5) ? PTR_W : 5;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [WIDE_W:0]   sum_t;

	localparam ptr_t  DEPTH_PTR  = ptr_t'(BUFFER_DEPTH);
	localparam wide_t DEPTH_WIDE = wide_t'(BUFFER_DEPTH);

	// Host actions
	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_RESTART = 3'd2;
	localparam logic [2:0] ACT_EVENT   = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	// Raw bus status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_REP_START  = 8'h10;
	localparam logic [7:0] ST_TX_ADR_ACK = 8'h18;
	localparam logic [7:0] ST_TX_DAT_ACK = 8'h28;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_RX_ADR_ACK = 8'h40;
	localparam logic [7:0] ST_RX_DAT_ACK = 8'h50;
	localparam logic [7:0] ST_RX_DAT_NAK = 8'h58;
	localparam logic [7:0] NO_ERROR_CODE = 8'hF8;

endpackage

// ----- rtl/i2c_master_transfer_sequencer_core.sv -----
// I2C master transfer sequencer. Each input transfer is a host action (load a message byte,
// start, restart, read a received byte) or a raw bus status event, and yields exactly one
// result transfer carrying the bus control decision and the sequencer status after that
// action. One item is taken every clock cycle when the output side keeps up. An accepted
// input transfer passes through the input register and then the result register before its
// result is presented. The state update in the processing step, a read of the 16-byte
// message register file plus a pointer compare, sets that rate. A result waiting on the
// output still lets one more input transfer be captured; after that the input stalls until
// the result is taken. Message bytes that were never loaded read back as undefined.
`include "i2c_master_transfer_sequencer_core_macros.svh"

module i2c_master_transfer_sequencer_core (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [3:0] index,
	input  logic [7:0] data_byte,
	input  logic [4:0] msg_size,
	input  logic [7:0] status_code,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       control_write,
	output logic       event_enable,
	output logic       ack_enable,
	output logic       start_request,
	output logic       stop_request,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       busy_res,
	output logic       last_ok,
	output logic [7:0] error_state,
	output logic [7:0] read_byte
);

	// input register
	logic       valid_s1;
	logic [2:0] action_s1;
	logic [3:0] index_s1;
	logic [7:0] data_byte_s1;
	logic [4:0] msg_size_s1;
	logic [7:0] status_code_s1;
	logic [7:0] rx_byte_s1;

	// result register
	logic       valid_s2;
	logic       control_write_s2;
	logic       ack_enable_s2;
	logic       start_request_s2;
	logic       stop_request_s2;
	logic       tx_valid_s2;
	logic [7:0] tx_byte_s2;
	logic       busy_s2;
	logic       last_ok_s2;
	logic [7:0] error_state_s2;
	logic [7:0] read_byte_s2;

	// sequencer state
	logic [7:0]       store_q [i2cmts_pkg::BUFFER_DEPTH];
	i2cmts_pkg::ptr_t byte_pointer_q;
	i2cmts_pkg::ptr_t transfer_length_q;
	logic             running_q;
	logic             done_ok_q;
	logic [7:0]       error_code_q;

	// step logic
	logic              adv;
	logic              step;
	i2cmts_pkg::ptr_t  ptr_eff;
	i2cmts_pkg::ptr_t  ptr_nx;
	i2cmts_pkg::ptr_t  len_nx;
	i2cmts_pkg::wide_t idx_plus1;
	logic              run_nx;
	logic              ok_nx;
	logic [7:0]        err_nx;
	logic              wr_en;
	i2cmts_pkg::addr_t wr_addr;
	logic [7:0]        wr_data;
	i2cmts_pkg::addr_t rd_addr;
	logic [7:0]        rd_data;
	logic              cw_nx;
	logic              ack_nx;
	logic              start_nx;
	logic              stop_nx;
	logic              txv_nx;
	logic [7:0]        txb_nx;
	logic [7:0]        rdb_nx;

	// handshake: process the held item whenever the result register can take it
	assign adv      = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// capture input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1      <= action;
			index_s1       <= index;
			data_byte_s1   <= data_byte;
			msg_size_s1    <= msg_size;
			status_code_s1 <= status_code;
			rx_byte_s1     <= rx_byte;
		end
	end

	// start codes rewind the pointer before the byte is picked
	always_comb begin
		if (status_code_s1 == i2cmts_pkg::ST_START || status_code_s1 == i2cmts_pkg::ST_REP_START) begin
			ptr_eff = '0;
		end else begin
			ptr_eff = byte_pointer_q;
		end
	end

	assign idx_plus1 = i2cmts_pkg::wide_t'(index_s1) + i2cmts_pkg::wide_t'(1);

	// single read port: read position on a host read, else the byte pointer
	assign rd_addr = (action_s1 == i2cmts_pkg::ACT_READ) ? i2cmts_pkg::addr_t'(idx_plus1)
	                                                      : i2cmts_pkg::addr_t'(ptr_eff);
	assign rd_data = store_q[rd_addr];

	// decide the step
	always_comb begin
		ptr_nx   = byte_pointer_q;
		len_nx   = transfer_length_q;
		run_nx   = running_q;
		ok_nx    = done_ok_q;
		err_nx   = error_code_q;
		wr_en    = 1'b0;
		wr_addr  = i2cmts_pkg::addr_t'(byte_pointer_q);
		wr_data  = rx_byte_s1;
		cw_nx    = 1'b0;
		ack_nx   = 1'b0;
		start_nx = 1'b0;
		stop_nx  = 1'b0;
		txv_nx   = 1'b0;
		txb_nx   = '0;
		rdb_nx   = '0;
		unique case (action_s1) inside
			i2cmts_pkg::ACT_LOAD: begin
				if (!running_q && i2cmts_pkg::wide_t'(index_s1) < i2cmts_pkg::DEPTH_WIDE) begin
					wr_en   = 1'b1;
					wr_addr = i2cmts_pkg::addr_t'(index_s1);
					wr_data = data_byte_s1;
				end
			end
			i2cmts_pkg::ACT_START, i2cmts_pkg::ACT_RESTART: begin
				if (!running_q) begin
					if (action_s1 == i2cmts_pkg::ACT_START) begin
						if (i2cmts_pkg::wide_t'(msg_size_s1) > i2cmts_pkg::DEPTH_WIDE) begin
							len_nx = i2cmts_pkg::DEPTH_PTR;
						end else begin
							len_nx = i2cmts_pkg::ptr_t'(msg_size_s1);
						end
					end
					ok_nx    = 1'b0;
					err_nx   = i2cmts_pkg::NO_ERROR_CODE;
					run_nx   = 1'b1;
					cw_nx    = 1'b1;
					start_nx = 1'b1;
				end
			end
			i2cmts_pkg::ACT_EVENT: begin
				if (running_q) begin
					cw_nx = 1'b1;
					unique case (status_code_s1) inside
						i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START,
						i2cmts_pkg::ST_TX_ADR_ACK, i2cmts_pkg::ST_TX_DAT_ACK: begin
							ptr_nx = ptr_eff;
							if (ptr_eff < transfer_length_q && ptr_eff < i2cmts_pkg::DEPTH_PTR) begin
								txv_nx = 1'b1;
								txb_nx = rd_data;
								ptr_nx = ptr_eff + i2cmts_pkg::ptr_t'(1);
							end else begin
								ok_nx   = 1'b1;
								run_nx  = 1'b0;
								stop_nx = 1'b1;
							end
						end
						i2cmts_pkg::ST_RX_DAT_ACK: begin
							if (byte_pointer_q < i2cmts_pkg::DEPTH_PTR) begin
								wr_en  = 1'b1;
								ptr_nx = byte_pointer_q + i2cmts_pkg::ptr_t'(1);
							end
							ack_nx = (i2cmts_pkg::sum_t'(ptr_nx) + i2cmts_pkg::sum_t'(1))
							         < i2cmts_pkg::sum_t'(transfer_length_q);
						end
						i2cmts_pkg::ST_RX_ADR_ACK: begin
							ack_nx = (i2cmts_pkg::sum_t'(byte_pointer_q) + i2cmts_pkg::sum_t'(1))
							         < i2cmts_pkg::sum_t'(transfer_length_q);
						end
						i2cmts_pkg::ST_RX_DAT_NAK: begin
							wr_en   = byte_pointer_q < i2cmts_pkg::DEPTH_PTR;
							ok_nx   = 1'b1;
							run_nx  = 1'b0;
							stop_nx = 1'b1;
						end
						i2cmts_pkg::ST_ARB_LOST: begin
							start_nx = 1'b1;
						end
						default: begin
							err_nx  = status_code_s1;
							run_nx  = 1'b0;
							stop_nx = 1'b1;
						end
					endcase
				end
			end
			i2cmts_pkg::ACT_READ: begin
				if (done_ok_q && idx_plus1 < i2cmts_pkg::DEPTH_WIDE) begin
					rdb_nx = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	// advance sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pointer_q    <= '0;
			transfer_length_q <= '0;
			running_q         <= 1'b0;
			done_ok_q         <= 1'b0;
			error_code_q      <= i2cmts_pkg::NO_ERROR_CODE;
		end else if (step) begin
			byte_pointer_q    <= ptr_nx;
			transfer_length_q <= len_nx;
			running_q         <= run_nx;
			done_ok_q         <= ok_nx;
			error_code_q      <= err_nx;
		end
	end

	// message store write
	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			control_write_s2 <= cw_nx;
			ack_enable_s2    <= ack_nx;
			start_request_s2 <= start_nx;
			stop_request_s2  <= stop_nx;
			tx_valid_s2      <= txv_nx;
			tx_byte_s2       <= txb_nx;
			busy_s2          <= run_nx;
			last_ok_s2       <= ok_nx;
			error_state_s2   <= err_nx;
			read_byte_s2     <= rdb_nx;
		end
	end

	assign out_valid     = valid_s2;
	assign control_write = control_write_s2;
	assign event_enable  = busy_s2;
	assign ack_enable    = ack_enable_s2;
	assign start_request = start_request_s2;
	assign stop_request  = stop_request_s2;
	assign tx_valid      = tx_valid_s2;
	assign tx_byte       = tx_byte_s2;
	assign busy_res      = busy_s2;
	assign last_ok       = last_ok_s2;
	assign error_state   = error_state_s2;
	assign read_byte     = read_byte_s2;

	// checks
	`I2CMTS_ASSERT_NOW(a_tx_needs_ctrl, clk, arst_n, valid_s2 && tx_valid_s2, control_write_s2)
	`I2CMTS_ASSERT_NOW(a_ptr_in_range, clk, arst_n, 1'b1, byte_pointer_q <= i2cmts_pkg::DEPTH_PTR)
	`I2CMTS_ASSERT_NOW(a_stall_blocks_in, clk, arst_n, valid_s1 && valid_s2 && !out_ready, !in_ready)
	`I2CMTS_ASSERT_NOW(a_run_rise, clk, arst_n, $rose(running_q),
		$past(step && (action_s1 == i2cmts_pkg::ACT_START || action_s1 == i2cmts_pkg::ACT_RESTART)))
	`I2CMTS_ASSERT_NOW(a_run_fall, clk, arst_n, $fell(running_q),
		$past(step && action_s1 == i2cmts_pkg::ACT_EVENT))

endmodule
